>>> rtl/integer_to_ascii_radix_defines.svh
// ----------------------------------------------------------------------------
// integer_to_ascii_radix assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

// property checked out of reset only
`define I2A_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property that must also hold across reset
`define I2A_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// shared types, constants and character mapping for integer_to_ascii_radix
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int IN_W       = 64;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int RADIX_W    = 5;
  localparam int STEP_BITS  = 4;  // dividend bits consumed per cycle
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_BASE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWERCASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_MIN  = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 5'd16;
  localparam logic [RADIX_W-1:0] BASE_RESET = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_CASE    = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;

  typedef struct packed {
    logic               start;  // load a new dividend and begin a digit
    logic               next;   // begin another digit from the held quotient
    logic [RADIX_W-1:0] radix;
  } div_ctrl_t;

  typedef struct packed {
    logic               done;   // one-cycle pulse, digit and quotient ready
    logic [DIGIT_W-1:0] digit;
    logic               q_zero;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic lower);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_UPPER_A + CHAR_W'(d - DIGIT_TEN) + (lower ? CHAR_CASE : '0);
    end
    return c;
  endfunction

endpackage

>>> rtl/i2a_divider.sv
// ----------------------------------------------------------------------------
// i2a_divider
// digit-serial long division of the held value by the radix, four bits a cycle
// ----------------------------------------------------------------------------
module i2a_divider #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  i2a_pkg::div_ctrl_t  ctrl,
  input  logic [((VALUE_WIDTH+i2a_pkg::STEP_BITS-1)/i2a_pkg::STEP_BITS)
                *i2a_pkg::STEP_BITS-1:0] value,
  output i2a_pkg::div_stat_t  stat
);

  localparam int QW    = ((VALUE_WIDTH + i2a_pkg::STEP_BITS - 1) / i2a_pkg::STEP_BITS)
                         * i2a_pkg::STEP_BITS;
  localparam int STEPS = QW / i2a_pkg::STEP_BITS;
  localparam int SW    = $clog2(STEPS + 1);

  logic [QW-1:0]                q_r, q_nxt;
  logic [i2a_pkg::DIGIT_W-1:0]  rem_r, rem_nxt;
  logic [SW-1:0]                cnt_r;
  logic                         busy_r;
  logic                         done_r;

  // four restoring-division steps on the shifted-out dividend bits
  always_comb begin
    logic [i2a_pkg::DIGIT_W:0] t;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    for (int k = 0; k < i2a_pkg::STEP_BITS; k++) begin
      t     = {rem_nxt, q_nxt[QW-1]};
      q_nxt = {q_nxt[QW-2:0], 1'b0};
      if (t >= ctrl.radix) begin
        rem_nxt  = i2a_pkg::DIGIT_W'(t - ctrl.radix);
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[i2a_pkg::DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctrl.start || ctrl.next) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= SW'(STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - SW'(1);
      if (cnt_r == SW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end else begin
      done_r <= 1'b0;
    end

    // datapath
    if (ctrl.start) begin
      q_r   <= value;
      rem_r <= '0;
    end else if (ctrl.next) begin
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.done   = done_r;
  assign stat.digit  = rem_r;
  assign stat.q_zero = ~|q_r;

endmodule

>>> rtl/integer_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// converts one integer per item into its ASCII text, one character per item
// ----------------------------------------------------------------------------
// usage
//   in_*  : one item carries the raw value in in_tdata; only the low
//           VALUE_WIDTH bits count, the top one is the sign in signed mode
//   out_* : one character per item, most significant digit first, a leading
//           '-' for negative values in signed mode, out_tlast on the final one
//   cfg_* : base (index 0), lowercase (index 1), signed_mode (index 2), written
//           while the block is idle; a base outside 8..16 is clamped
// timing
//   each digit divides the whole held quotient, VALUE_WIDTH rounded up to a
//   multiple of 4 bits, four bits a cycle, and is stored once done; the first
//   character follows the last digit, then one a cycle while the receiver
//   takes them; the input is free again once the final character is loaded
//   into the output register; one item at a time
// reset
//   synchronous, clears the control state and returns base to 10, upper case
//   letters and signed mode
// back-pressure
//   a stalled receiver holds the current character in the output register;
//   the next item is accepted while the final character is still waiting
// ----------------------------------------------------------------------------
module integer_to_ascii_radix #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_CHARS   = 23
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [i2a_pkg::IN_W-1:0]         in_tdata,   // [63:0] value_bits
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [i2a_pkg::CHAR_W-1:0]       out_tdata,  // [7:0] ascii_char
  output logic                             out_tlast,  // last_char
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [i2a_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i2a_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int QW    = ((VALUE_WIDTH + i2a_pkg::STEP_BITS - 1) / i2a_pkg::STEP_BITS)
                         * i2a_pkg::STEP_BITS;
  localparam int DEPTH = (VALUE_WIDTH + 2) / 3;       // most digits, at radix 8
  localparam int IW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int MAXV  = (MAX_CHARS > DEPTH + 1) ? MAX_CHARS : DEPTH + 1;
  localparam int LW    = $clog2(MAXV + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t                       state_r, state_nxt;

  // configuration registers
  logic [i2a_pkg::RADIX_W-1:0]  base_r;
  logic                         lower_r;
  logic                         signed_r;
  logic [i2a_pkg::RADIX_W-1:0]  radix;

  // per-item control
  logic                         neg_r, neg_nxt;
  logic [NW-1:0]                nd_r, nd_nxt;
  logic [IW-1:0]                rd_idx_r, rd_idx_nxt;
  logic                         sign_pend_r, sign_pend_nxt;
  logic [LW-1:0]                left_r, left_nxt;
  logic [LW-1:0]                total;

  // digit store, least significant digit at index 0
  logic [i2a_pkg::DIGIT_W-1:0]  digits_r [DEPTH];
  logic                         dig_wr;

  // output register
  logic                         out_tvalid_r, out_tvalid_nxt;
  logic [i2a_pkg::CHAR_W-1:0]   out_data_r, out_data_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_load;

  // input magnitude
  logic                         in_acc;
  logic [VALUE_WIDTH-1:0]       v;
  logic                         v_neg;
  logic [VALUE_WIDTH-1:0]       mag;

  i2a_pkg::div_ctrl_t           div_ctrl;
  i2a_pkg::div_stat_t           div_stat;

  // clamp radix into 8..16
  always_comb begin
    priority if (base_r < i2a_pkg::RADIX_MIN) begin
      radix = i2a_pkg::RADIX_MIN;
    end else if (base_r > i2a_pkg::RADIX_MAX) begin
      radix = i2a_pkg::RADIX_MAX;
    end else begin
      radix = base_r;
    end
  end

  // nothing is taken while reset is held
  assign in_tready = (state_r == S_IDLE) && rst_n;
  assign in_acc    = in_tvalid && in_tready;

  // sign split; the most negative value maps onto its own bit pattern,
  // which read unsigned is the exact magnitude
  assign v     = in_tdata[VALUE_WIDTH-1:0];
  assign v_neg = signed_r && v[VALUE_WIDTH-1];
  assign mag   = v_neg ? (~v + VALUE_WIDTH'(1)) : v;

  assign div_ctrl.start = in_acc;
  assign div_ctrl.next  = (state_r == S_DIV) && div_stat.done && !div_stat.q_zero;
  assign div_ctrl.radix = radix;

  i2a_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (div_ctrl),
    .value (QW'(mag)),
    .stat  (div_stat)
  );

  // characters in the whole text once the last digit lands
  assign total = LW'(neg_r) + LW'(nd_r) + LW'(1);

  assign out_load = !out_tvalid_r || out_tready;
  assign dig_wr   = (state_r == S_DIV) && div_stat.done;

  always_comb begin
    state_nxt      = state_r;
    neg_nxt        = neg_r;
    nd_nxt         = nd_r;
    rd_idx_nxt     = rd_idx_r;
    sign_pend_nxt  = sign_pend_r;
    left_nxt       = left_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          neg_nxt   = v_neg;
          nd_nxt    = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          nd_nxt = nd_r + NW'(1);
          if (div_stat.q_zero) begin
            rd_idx_nxt    = nd_r[IW-1:0];
            sign_pend_nxt = neg_r;
            left_nxt      = (total > LW'(MAX_CHARS)) ? LW'(MAX_CHARS) : total;
            state_nxt     = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_tvalid_nxt = 1'b1;
          out_last_nxt   = (left_r == LW'(1));
          left_nxt       = left_r - LW'(1);
          if (sign_pend_r) begin
            out_data_nxt  = i2a_pkg::CHAR_MINUS;
            sign_pend_nxt = 1'b0;
          end else begin
            out_data_nxt = i2a_pkg::digit_char(digits_r[rd_idx_r], lower_r);
            rd_idx_nxt   = rd_idx_r - IW'(1);
          end
          if (left_r == LW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      base_r       <= i2a_pkg::BASE_RESET;
      lower_r      <= 1'b0;
      signed_r     <= 1'b1;
      out_tvalid_r <= 1'b0;
      neg_r        <= 1'b0;
      nd_r         <= '0;
      sign_pend_r  <= 1'b0;
      left_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      neg_r        <= neg_nxt;
      nd_r         <= nd_nxt;
      sign_pend_r  <= sign_pend_nxt;
      left_r       <= left_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          i2a_pkg::REG_BASE:        base_r   <= cfg_wdata;
          i2a_pkg::REG_LOWERCASE:   lower_r  <= cfg_wdata[0];
          i2a_pkg::REG_SIGNED_MODE: signed_r <= cfg_wdata[0];
          default: ;  // no register at this index
        endcase
      end
    end

    // payload
    rd_idx_r   <= rd_idx_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    if (dig_wr) begin
      digits_r[nd_r[IW-1:0]] <= div_stat.digit;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/i2a_checker.sv
// ----------------------------------------------------------------------------
// i2a_checker
// port-level checks for integer_to_ascii_radix, bound to the top level
// ----------------------------------------------------------------------------
`include "integer_to_ascii_radix_defines.svh"

module i2a_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [i2a_pkg::CHAR_W-1:0]  out_tdata,
  input logic                        out_tlast
);

  // a stalled character holds
  `I2A_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled character changed")

  // reset empties the output register
  `I2A_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_tvalid, "output valid after reset")

  // an accepted item keeps the block busy
  `I2A_ASSERT(a_busy, in_tvalid && in_tready |=> !in_tready, "input ready right after accept")

  // when idle, only the final character of the previous text may still wait
  `I2A_ASSERT(a_idle_last, in_tready && out_tvalid |-> out_tlast, "idle with non-final character pending")

  // only sign, digit and letter characters appear
  `I2A_ASSERT(a_char_set, out_tvalid |-> (out_tdata == 8'h2d) || (out_tdata >= 8'h30 && out_tdata <= 8'h39) || (out_tdata >= 8'h41 && out_tdata <= 8'h46) || (out_tdata >= 8'h61 && out_tdata <= 8'h66), "illegal character")

endmodule

bind integer_to_ascii_radix i2a_checker u_i2a_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
